### hw/rtl/lbct_pkg.sv
// shared types and constants for the learned binned characteristic table
package lbct_pkg;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_POSITION_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_SCALE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRIES_IN_USE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_ESTIMATE = 3'd4;

   localparam logic [1:0] CMD_LOOKUP_POS = 2'd0;
   localparam logic [1:0] CMD_UPDATE_POS = 2'd1;
   localparam logic [1:0] CMD_LOOKUP_IDX = 2'd2;
   localparam logic [1:0] CMD_UPDATE_IDX = 2'd3;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   localparam logic signed [31:0] RESET_POSITION_OFFSET  = 32'sd0;
   localparam logic [31:0]        RESET_INDEX_SCALE      = 32'd65536;
   localparam logic [8:0]         RESET_ENTRIES_IN_USE   = 9'd256;
   localparam logic [16:0]        RESET_SMOOTHING_WEIGHT = 17'd32768;
   localparam logic signed [31:0] RESET_INITIAL_ESTIMATE = 32'sd0;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] position;
      logic [7:0]         entry_index;
      logic signed [31:0] measured_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] estimate;
      logic [7:0]         used_index;
   } rsp_type;

   typedef struct packed {
      logic fill_start;
      logic fill_en;
      logic latch;
      logic diff_en;
      logic scale_en;
      logic addr_en;
      logic sub_en;
      logic wmul_en;
      logic write_en;
   } ctl_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic init_write;
   } ctl_status_type;

endpackage

### hw/rtl/lbct_ctrl.sv
// sequencing state machine for table fill and item processing
module lbct_ctrl
   import lbct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  ctl_status_type sts,
   output ctl_cmd_type    ctl
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_ADDR  = 3'd4;
   localparam logic [2:0] ST_SUB   = 3'd5;
   localparam logic [2:0] ST_WMUL  = 3'd6;
   localparam logic [2:0] ST_WRITE = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.init_write) begin
               ctl.fill_start = 1'b1;
               state_in       = ST_FILL;
            end else if (start) begin
               ctl.latch = 1'b1;
               state_in  = ST_DIFF;
            end
         end
         ST_FILL: begin
            if (sts.init_write) begin
               ctl.fill_start = 1'b1;
            end else begin
               ctl.fill_en = 1'b1;
               if (sts.fill_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIFF: begin
            ctl.diff_en = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            ctl.scale_en = 1'b1;
            state_in     = ST_ADDR;
         end
         ST_ADDR: begin
            ctl.addr_en = 1'b1;
            state_in    = ST_SUB;
         end
         ST_SUB: begin
            ctl.sub_en = 1'b1;
            state_in   = ST_WMUL;
         end
         ST_WMUL: begin
            ctl.wmul_en = 1'b1;
            state_in    = ST_WRITE;
         end
         ST_WRITE: begin
            ctl.write_en = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE) || sts.init_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/lbct_datapath.sv
// registers, index mapping, table memory and update arithmetic
module lbct_datapath
   import lbct_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          ctl,
   output ctl_status_type       sts,
   input  req_type              req_item,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CW    = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

   // configuration registers
   logic signed [31:0] offset_ff, offset_in;
   logic [31:0]        scale_ff, scale_in;
   logic [8:0]         entries_ff, entries_in;
   logic [16:0]        weight_ff, weight_in;
   logic signed [31:0] init_ff, init_in;

   always_comb begin
      offset_in  = offset_ff;
      scale_in   = scale_ff;
      entries_in = entries_ff;
      weight_in  = weight_ff;
      init_in    = init_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_POSITION_OFFSET:  offset_in  = $signed(csr_data);
            REG_INDEX_SCALE:      scale_in   = csr_data;
            REG_ENTRIES_IN_USE:   entries_in = csr_data[8:0];
            REG_SMOOTHING_WEIGHT: weight_in  = csr_data[16:0];
            REG_INITIAL_ESTIMATE: init_in    = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= RESET_POSITION_OFFSET;
         scale_ff   <= RESET_INDEX_SCALE;
         entries_ff <= RESET_ENTRIES_IN_USE;
         weight_ff  <= RESET_SMOOTHING_WEIGHT;
         init_ff    <= RESET_INITIAL_ESTIMATE;
      end else begin
         offset_ff  <= offset_in;
         scale_ff   <= scale_in;
         entries_ff <= entries_in;
         weight_ff  <= weight_in;
         init_ff    <= init_in;
      end
   end

   assign sts.init_write = csr_valid && (csr_index == REG_INITIAL_ESTIMATE);

   // fill sweep counter
   logic [IDX_W-1:0] fill_cnt_ff, fill_cnt_in;

   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      if (ctl.fill_start) begin
         fill_cnt_in = '0;
      end else if (ctl.fill_en) begin
         fill_cnt_in = fill_cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
      end else begin
         fill_cnt_ff <= fill_cnt_in;
      end
   end

   assign sts.fill_last = (fill_cnt_ff == IDX_W'(TABLE_DEPTH - 1));

   // last usable index
   logic [CW-1:0]    entries_ext;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      entries_ext = CW'(entries_ff);
      if (entries_ext == '0) begin
         last_idx = '0;
      end else if (entries_ext > CW'(TABLE_DEPTH)) begin
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = IDX_W'(entries_ext - CW'(1));
      end
   end

   // item pipeline registers
   req_type            item_ff;
   logic signed [32:0] diff_ff;
   logic [31:0]        t_ff;
   logic [IDX_W-1:0]   k_ff;
   logic signed [31:0] rd_ff;
   logic signed [32:0] d2_ff;
   logic signed [50:0] p_ff;

   logic [63:0]        scale_prod;
   logic               by_pos;
   logic               is_update;
   logic [31:0]        pos_clamped;
   logic [31:0]        idx_clamped;
   logic [IDX_W-1:0]   k_sel;
   logic [16:0]        w_eff;
   logic signed [50:0] delta;
   logic signed [31:0] new_value;
   logic signed [31:0] est;

   assign scale_prod = 64'(diff_ff[31:0]) * 64'(scale_ff);
   assign by_pos     = (item_ff.cmd == CMD_LOOKUP_POS) || (item_ff.cmd == CMD_UPDATE_POS);
   assign is_update  = (item_ff.cmd == CMD_UPDATE_POS) || (item_ff.cmd == CMD_UPDATE_IDX);
   assign pos_clamped = (t_ff > 32'(last_idx)) ? 32'(last_idx) : t_ff;
   assign idx_clamped = (32'(item_ff.entry_index) > 32'(last_idx)) ? 32'(last_idx)
                                                                   : 32'(item_ff.entry_index);
   assign k_sel      = by_pos ? IDX_W'(pos_clamped) : IDX_W'(idx_clamped);
   assign w_eff      = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
   assign delta      = p_ff >>> 16;
   assign new_value  = rd_ff + delta[31:0];
   assign est        = is_update ? new_value : rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         item_ff <= req_item;
      end
      if (ctl.diff_en) begin
         diff_ff <= {item_ff.position[31], item_ff.position} - {offset_ff[31], offset_ff};
      end
      if (ctl.scale_en) begin
         t_ff <= (diff_ff > 33'sd0) ? scale_prod[63:32] : 32'd0;
      end
      if (ctl.addr_en) begin
         k_ff <= k_sel;
      end
      if (ctl.sub_en) begin
         d2_ff <= {item_ff.measured_value[31], item_ff.measured_value} - {rd_ff[31], rd_ff};
      end
      if (ctl.wmul_en) begin
         p_ff <= 51'($signed({1'b0, w_eff}) * d2_ff);
      end
   end

   // table memory
   logic [31:0] entry_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.fill_en) begin
         entry_mem[fill_cnt_ff] <= init_ff;
      end else if (ctl.write_en && is_update) begin
         entry_mem[k_ff] <= new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.addr_en) begin
         rd_ff <= $signed(entry_mem[k_sel]);
      end
   end

   // result register
   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.write_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         rsp_item_ff.estimate   <= est;
         rsp_item_ff.used_index <= 8'(k_ff);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### hw/rtl/learned_binned_characteristic_table.sv
// top level of the learned binned characteristic table
// Usage:
//   An item (req_item) is taken at a clock edge where start is high and busy is low.
//   Its command looks up or updates one table entry, addressed by position or index.
//   The result (rsp_item) shows for exactly one cycle with rsp_strobe high; the
//   receiver cannot stall, so it must capture the result in that cycle.
//   Sequence: after the accepting edge the item passes the states offset subtract,
//   index multiply, memory read, subtract, weight multiply and write-back in order;
//   rsp_strobe is registered from write-back. The next item can be accepted in the
//   cycle the result is shown, and not before.
//   Configuration: csr_valid/csr_index/csr_data, always ready. Writing
//   initial_estimate while no item is in process refills the table: busy stays
//   high while the fill sweep writes one entry per cycle, restarting on a new write.
//   Reset (synchronous, active high) restores register defaults and runs the
//   same fill with zero; busy is high until it finishes.
module learned_binned_characteristic_table
   import lbct_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   ctl_cmd_type    ctl;
   ctl_status_type sts;

   assign csr_ready = 1'b1;

   lbct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   lbct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### dv/tb_top.sv
// self-checking testbench for the learned binned characteristic table
module tb_top
   import lbct_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   // shadow copy of the table and its registers
   logic signed [31:0] est_table [256];
   logic signed [31:0] reg_offset;
   logic [31:0]        reg_scale;
   logic [8:0]         reg_entries;
   logic [16:0]        reg_weight;
   logic signed [31:0] reg_init;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      fail_count = 0;
   int      gap_left = 0;
   int      burst_left = 0;

   learned_binned_characteristic_table u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
         REG_POSITION_OFFSET:  reg_offset = data;
         REG_INDEX_SCALE:      reg_scale = data;
         REG_ENTRIES_IN_USE:   reg_entries = data[8:0];
         REG_SMOOTHING_WEIGHT: reg_weight = data[16:0];
         REG_INITIAL_ESTIMATE: begin
            reg_init = data;
            foreach (est_table[i]) est_table[i] = data;
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type predict_entry(req_type r);
      rsp_type     res;
      logic [8:0]  n;
      logic [8:0]  last;
      logic [7:0]  k;
      longint      diff;
      logic [63:0] prod;
      longint      gain;
      longint      p;
      n = (reg_entries == 9'd0) ? 9'd1 : (reg_entries > 9'd256) ? 9'd256 : reg_entries;
      last = n - 9'd1;
      if (r.cmd == CMD_LOOKUP_POS || r.cmd == CMD_UPDATE_POS) begin
         diff = longint'($signed(r.position)) - longint'(reg_offset);
         if (diff <= 0) begin
            k = 8'd0;
         end else begin
            prod = (64'(diff) * 64'(reg_scale)) >> 32;
            k = (prod > 64'(last)) ? last[7:0] : prod[7:0];
         end
      end else begin
         k = (r.entry_index > last) ? last[7:0] : r.entry_index;
      end
      if (r.cmd == CMD_UPDATE_POS || r.cmd == CMD_UPDATE_IDX) begin
         gain = (reg_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(reg_weight);
         p = gain * (longint'($signed(r.measured_value)) - longint'(est_table[k]));
         est_table[k] = est_table[k] + 32'(p >>> 16);
      end
      res.estimate = est_table[k];
      res.used_index = k;
      return res;
   endfunction

   function automatic void queue_item(logic [1:0] cmd, logic [31:0] pos, logic [7:0] idx,
                                      logic [31:0] meas);
      req_type r;
      r.cmd = cmd;
      r.position = pos;
      r.entry_index = idx;
      r.measured_value = meas;
      pending_reqs.push_back(r);
   endfunction

   task automatic queue_random_items(int count);
      logic [31:0] pos;
      logic [31:0] meas;
      logic [7:0]  idx;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0:       pos = $urandom;
            1:       pos = reg_offset - 32'($urandom_range(0, 1 << 20));
            default: pos = reg_offset + 32'($urandom_range(0, 1 << 24));
         endcase
         meas = ($urandom_range(0, 1) == 0) ? $urandom
                                             : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
         idx = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
         queue_item(2'($urandom_range(0, 3)), pos, idx, meas);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      csr_valid <= 1'b0;
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // wait until every queued transaction has been sent and answered
   task automatic drain_block();
      @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (start && !busy) expected_rsps.push_back(predict_entry(req_item));
         if (!(start && busy)) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_item <= pending_reqs.pop_front();
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected transaction: estimate %0h used_index %0d",
                   rsp_item.estimate, rsp_item.used_index);
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_item.estimate !== exp_rsp.estimate) begin
               $error("estimate: expected %0h, actual %0h", exp_rsp.estimate, rsp_item.estimate);
               fail_count++;
            end
            if (rsp_item.used_index !== exp_rsp.used_index) begin
               $error("used_index: expected %0d, actual %0d",
                      exp_rsp.used_index, rsp_item.used_index);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL learned_binned_characteristic_table");
      $finish;
   end

   initial begin
      reg_offset  = RESET_POSITION_OFFSET;
      reg_scale   = RESET_INDEX_SCALE;
      reg_entries = RESET_ENTRIES_IN_USE;
      reg_weight  = RESET_SMOOTHING_WEIGHT;
      reg_init    = RESET_INITIAL_ESTIMATE;
      foreach (est_table[i]) est_table[i] = RESET_INITIAL_ESTIMATE;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      // directed: index ends, rounding toward minus infinity, position edges
      queue_item(CMD_LOOKUP_IDX, 32'h0, 8'd0, 32'h0);
      queue_item(CMD_LOOKUP_IDX, 32'h0, 8'd255, 32'h0);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd0, 32'h7FFF_FFFF);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd0, 32'h8000_0000);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd255, 32'hFFFF_FFFF);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd255, 32'h0000_0001);
      queue_item(CMD_LOOKUP_POS, 32'h0, 8'd0, 32'h0);
      queue_item(CMD_LOOKUP_POS, 32'hFFFF_FFFF, 8'd0, 32'h0);
      queue_item(CMD_LOOKUP_POS, 32'h8000_0000, 8'd0, 32'h0);
      queue_item(CMD_LOOKUP_POS, 32'h7FFF_FFFF, 8'd0, 32'h0);
      queue_item(CMD_LOOKUP_POS, 32'h0005_8000, 8'd0, 32'h0);
      queue_item(CMD_UPDATE_POS, 32'h0003_0000, 8'd0, 32'h1234_5678);
      queue_item(CMD_LOOKUP_POS, 32'h0003_0000, 8'd0, 32'h0);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd10, 32'h7FFF_FFFF);
      queue_item(CMD_UPDATE_POS, 32'h000A_FFFF, 8'd0, 32'h8000_0000);
      drain_block();

      // small table: index clamp and position saturation
      write_csr(REG_ENTRIES_IN_USE, 32'd4);
      write_csr(REG_SMOOTHING_WEIGHT, 32'(WEIGHT_ONE));
      queue_item(CMD_LOOKUP_IDX, 32'h0, 8'd200, 32'h0);
      queue_item(CMD_UPDATE_IDX, 32'h0, 8'd255, 32'h7FFF_FFFF);
      queue_item(CMD_LOOKUP_POS, 32'h7FFF_FFFF, 8'd0, 32'h0);
      queue_item(CMD_UPDATE_POS, 32'h0002_0000, 8'd0, 32'h8000_0000);
      drain_block();

      write_csr(REG_POSITION_OFFSET, 32'h8000_0000);
      write_csr(REG_INDEX_SCALE, 32'hFFFF_FFFF);
      write_csr(REG_ENTRIES_IN_USE, 32'd1);
      write_csr(REG_SMOOTHING_WEIGHT, 32'd0);
      write_csr(REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
      queue_random_items(100);
      drain_block();

      write_csr(REG_POSITION_OFFSET, 32'h7FFF_FFFF);
      write_csr(REG_INDEX_SCALE, 32'd0);
      write_csr(REG_ENTRIES_IN_USE, 32'hFFFF_FE00);
      write_csr(REG_SMOOTHING_WEIGHT, 32'h0001_FFFF);
      write_csr(REG_INITIAL_ESTIMATE, 32'h8000_0000);
      for (int r = REG_INITIAL_ESTIMATE + 1; r < (1 << CSR_IDX_W); r++)
         write_csr(CSR_IDX_W'(r), $urandom);
      queue_random_items(100);
      drain_block();

      write_csr(REG_POSITION_OFFSET, 32'd0);
      write_csr(REG_INDEX_SCALE, 32'd1);
      write_csr(REG_ENTRIES_IN_USE, 32'd511);
      write_csr(REG_SMOOTHING_WEIGHT, 32'd1);
      queue_random_items(100);
      drain_block();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_POSITION_OFFSET, $urandom);
         write_csr(REG_INDEX_SCALE, ($urandom_range(0, 1) == 0) ? $urandom
                                    : 32'($urandom_range(1 << 12, 1 << 20)));
         write_csr(REG_ENTRIES_IN_USE, ($urandom & 32'hFFFF_FE00) | $urandom_range(0, 511));
         write_csr(REG_SMOOTHING_WEIGHT,
                   ($urandom & 32'hFFFE_0000) | $urandom_range(0, 70000));
         if ($urandom_range(0, 1) == 0) write_csr(REG_INITIAL_ESTIMATE, $urandom);
         queue_random_items(100);
         drain_block();
      end

      if (fail_count == 0) begin
         $display("PASS learned_binned_characteristic_table");
      end else begin
         $display("FAIL learned_binned_characteristic_table");
      end
      $finish;
   end

endmodule
